[hdl/rria_pkg.sv]
// Shared types and codes for the round-robin ID slot allocator.
// No dependencies; every other file of the block but rria_ram imports this package.
package rria_pkg;

  // Field widths of the item and result
  localparam int ID_W    = 10;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;

  // Occupancy bitmap word geometry
  localparam int WORD_W  = 32;
  localparam int WORD_AW = 5;

  // Mode codes on the item
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 2'd3;

  // Status codes on the result
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   slot_id;
    logic              is_current;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [STAT_W-1:0] status;
    logic              found;
    logic              occupied;
  } result_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_LOOKUP,
    OP_FLUSH
  } op_t;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    op_t             op;
    logic            in_range;
    logic            cur;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FL_RD,
    S_FL_WR,
    S_RL_RD,
    S_RL_WR,
    S_LK_RD,
    S_LK_EV,
    S_SCAN,
    S_AL_WR
  } st_t;

endpackage

[hdl/rria_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rria_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rria_front.sv]
// Front end: accepts items, decodes the mode and range-checks the ID.
// Depends on rria_pkg; feeds rria_queue.
module rria_front
  import rria_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t req,
  output logic  busy,
  input  logic  q_full,
  output logic  push,
  output cmd_t  cmd
);

  logic fr_vld;
  cmd_t fr_cmd;
  cmd_t cls;
  logic accept;

  // Hold off new items only while the held one cannot move on
  assign busy   = fr_vld & q_full;
  assign accept = start & ~busy;
  assign push   = fr_vld & ~q_full;
  assign cmd    = fr_cmd;

  // Classify the incoming item
  always_comb begin
    cls.id       = req.slot_id;
    cls.cur      = req.is_current;
    cls.in_range = 32'(req.slot_id) < 32'(SLOT_COUNT);
    case (req.mode)
      MODE_ALLOC:   cls.op = OP_ALLOC;
      MODE_RELEASE: cls.op = OP_RELEASE;
      MODE_LOOKUP:  cls.op = OP_LOOKUP;
      MODE_FLUSH:   cls.op = OP_FLUSH;
      default:      cls.op = OP_FLUSH;
    endcase
  end

  // Hold one classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_vld <= 1'b0;
    end else if (accept) begin
      fr_vld <= 1'b1;
    end else if (push) begin
      fr_vld <= 1'b0;
    end
    if (accept) begin
      fr_cmd <= cls;
    end
  end

endmodule

[hdl/rria_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on rria_pkg.
module rria_queue
  import rria_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign dout  = ent[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

endmodule

[hdl/rria_back.sv]
// Back end: executes commands against the occupancy bitmap RAM.
// Depends on rria_pkg and rria_ram; fed by rria_queue.
module rria_back
  import rria_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    empty,
  input  cmd_t    head,
  output logic    pop,
  output logic    done,
  output result_t rsp
);

  localparam int SW     = $clog2(SLOT_COUNT);
  localparam int SWX    = (SW > WORD_AW) ? SW : WORD_AW + 1;
  localparam int ROWS   = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW     = $clog2(ROWS + 2);
  localparam int TAIL   = SLOT_COUNT % WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));

  function automatic logic [ROW_AW-1:0] row_of(input logic [SW-1:0] s);
    logic [SWX-1:0] x;
    x = SWX'(s);
    return ROW_AW'(x >> WORD_AW);
  endfunction

  function automatic logic [WORD_AW-1:0] bit_of(input logic [SW-1:0] s);
    logic [SWX-1:0] x;
    x = SWX'(s);
    return x[WORD_AW-1:0];
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [ROW_AW-1:0] r,
                                            input logic [WORD_AW-1:0] b);
    logic [SWX-1:0] x;
    x = (SWX'(r) << WORD_AW) | SWX'(b);
    return SW'(x);
  endfunction

  st_t state;
  st_t state_next;

  cmd_t               cmd;
  logic [SW-1:0]      last_given;
  logic [SW-1:0]      pending;
  logic [SW-1:0]      start_slot;
  logic [SW-1:0]      al_slot;
  logic [WORD_W-1:0]  al_word;
  logic [CW-1:0]      iss_cnt;
  logic [ROW_AW-1:0]  iss_addr;
  logic               q_vld;
  logic [CW-1:0]      q_cnt;
  logic [ROW_AW-1:0]  q_addr;
  logic [ROW_AW-1:0]  raddr_q;
  logic [ROWS-1:0]    row_vld;

  logic               we;
  logic [ROW_AW-1:0]  waddr;
  logic [WORD_W-1:0]  wdata;
  logic [ROW_AW-1:0]  raddr;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  rd_word;

  logic               fin;
  result_t            rsp_next;
  logic [SW:0]        lg_inc;
  logic [SW-1:0]      step;
  logic [SW-1:0]      h_slot;
  logic [SW-1:0]      cmd_slot;
  logic               pend_nz;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  scan_word;
  logic [WORD_W-1:0]  free_vec;
  logic               hit;
  logic [WORD_AW-1:0] hit_bit;
  logic               occ;

  rria_ram #(
    .W     (WORD_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Derived values
  assign lg_inc   = {1'b0, last_given} + (SW + 1)'(1);
  assign step     = (lg_inc >= (SW + 1)'(SLOT_COUNT)) ? SW'(1) : SW'(lg_inc);
  assign h_slot   = SW'(head.id);
  assign cmd_slot = SW'(cmd.id);
  assign pend_nz  = pending != '0;
  assign rd_word  = row_vld[raddr_q] ? rd_data : '0;
  assign occ      = rd_word[bit_of(cmd_slot)];

  // Mask the scanned word: slots past the table, and the split start word
  always_comb begin
    lo_mask   = (WORD_W'(1) << bit_of(start_slot)) - WORD_W'(1);
    scan_word = rd_word;
    if (q_addr == ROW_AW'(ROWS - 1)) begin
      scan_word = scan_word | TAIL_MASK;
    end
    if (q_cnt == '0) begin
      scan_word = scan_word | lo_mask;
    end
    if (q_cnt == CW'(ROWS)) begin
      scan_word = scan_word | ~lo_mask;
    end
    free_vec = ~scan_word;
    hit      = q_vld && (free_vec != '0);
    hit_bit  = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        hit_bit = WORD_AW'(i);
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM control and result
  always_comb begin
    state_next         = state;
    pop                = 1'b0;
    fin                = 1'b0;
    we                 = 1'b0;
    waddr              = row_of(cmd_slot);
    wdata              = rd_word & ~(WORD_W'(1) << bit_of(cmd_slot));
    raddr              = iss_addr;
    rsp_next.result_id = cmd.id;
    rsp_next.status    = STATUS_OK;
    rsp_next.found     = 1'b0;
    rsp_next.occupied  = 1'b0;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          pop                = 1'b1;
          rsp_next.result_id = head.id;
          case (head.op)
            OP_ALLOC: state_next = S_SCAN;
            OP_RELEASE: begin
              if (!head.in_range) begin
                fin             = 1'b1;
                rsp_next.status = STATUS_RANGE;
              end else if (pend_nz) begin
                state_next = S_FL_RD;
              end else if (head.cur) begin
                fin = 1'b1;
              end else begin
                state_next = S_RL_RD;
              end
            end
            OP_LOOKUP: begin
              if (!head.in_range) begin
                fin             = 1'b1;
                rsp_next.status = STATUS_RANGE;
              end else begin
                state_next = S_LK_RD;
              end
            end
            OP_FLUSH: begin
              if (pend_nz) begin
                state_next = S_FL_RD;
              end else begin
                fin                = 1'b1;
                rsp_next.result_id = '0;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FL_RD: begin
        raddr      = row_of(pending);
        state_next = S_FL_WR;
      end
      S_FL_WR: begin
        we    = 1'b1;
        waddr = row_of(pending);
        wdata = rd_word & ~(WORD_W'(1) << bit_of(pending));
        if (cmd.op == OP_FLUSH) begin
          fin                = 1'b1;
          rsp_next.result_id = '0;
          state_next         = S_IDLE;
        end else if (cmd.cur) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_RL_RD;
        end
      end
      S_RL_RD: begin
        raddr      = row_of(cmd_slot);
        state_next = S_RL_WR;
      end
      S_RL_WR: begin
        we         = 1'b1;
        fin        = 1'b1;
        state_next = S_IDLE;
      end
      S_LK_RD: begin
        raddr      = row_of(cmd_slot);
        state_next = S_LK_EV;
      end
      S_LK_EV: begin
        fin               = 1'b1;
        rsp_next.occupied = occ;
        rsp_next.found    = occ && !(pend_nz && pending == cmd_slot);
        state_next        = S_IDLE;
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_AL_WR;
        end else if (q_vld && q_cnt == CW'(ROWS)) begin
          fin                = 1'b1;
          rsp_next.result_id = '0;
          rsp_next.status    = STATUS_FULL;
          state_next         = S_IDLE;
        end
      end
      S_AL_WR: begin
        we                 = 1'b1;
        waddr              = row_of(al_slot);
        wdata              = al_word | (WORD_W'(1) << bit_of(al_slot));
        fin                = 1'b1;
        rsp_next.result_id = ID_W'(al_slot);
        state_next         = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state: ID pointers, row valid bits, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      last_given <= '0;
      pending    <= '0;
      row_vld    <= '0;
      done       <= 1'b0;
      q_vld      <= 1'b0;
    end else begin
      done <= fin;
      if (we) begin
        row_vld[waddr] <= 1'b1;
      end
      if (state == S_IDLE && pop) begin
        q_vld <= 1'b0;
        if (head.op == OP_ALLOC) begin
          last_given <= step;
        end
        if (head.op == OP_RELEASE && head.in_range && !pend_nz && head.cur) begin
          pending <= h_slot;
        end
      end
      if (state == S_FL_WR) begin
        pending <= (cmd.op == OP_RELEASE && cmd.cur) ? cmd_slot : '0;
      end
      if (state == S_SCAN) begin
        if (hit) begin
          last_given <= slot_of(q_addr, hit_bit);
          q_vld      <= 1'b0;
        end else begin
          q_vld <= iss_cnt <= CW'(ROWS);
        end
      end
    end
  end

  // Datapath: command, scan pointers, pick, result payload
  always_ff @(posedge clk) begin
    raddr_q <= raddr;
    if (fin) begin
      rsp <= rsp_next;
    end
    if (pop) begin
      cmd <= head;
    end
    if (state == S_IDLE && pop) begin
      start_slot <= step;
      iss_cnt    <= '0;
      iss_addr   <= row_of(step);
    end
    if (state == S_SCAN) begin
      if (hit) begin
        al_slot <= slot_of(q_addr, hit_bit);
        al_word <= rd_word;
      end else if (iss_cnt <= CW'(ROWS)) begin
        q_cnt    <= iss_cnt;
        q_addr   <= iss_addr;
        iss_cnt  <= iss_cnt + CW'(1);
        iss_addr <= (iss_addr == ROW_AW'(ROWS - 1)) ? '0 : iss_addr + ROW_AW'(1);
      end
    end
  end

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_AL_WR) |-> !al_word[bit_of(al_slot)])
    else $error("allocation sets a slot that is already occupied");

  a_alloc_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_AL_WR) |-> (32'(al_slot) < 32'(SLOT_COUNT)))
    else $error("allocated slot lies past the table");

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    32'(pending) < 32'(SLOT_COUNT))
    else $error("pending slot lies past the table");

  a_row_vld_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((row_vld & $past(row_vld)) == $past(row_vld)))
    else $error("bitmap row lost its written mark");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && q_vld) |-> (q_cnt <= CW'(ROWS)))
    else $error("scan evaluated a word past the wrap");

endmodule

[hdl/round_robin_id_slot_allocator.sv]
// Top level of the round-robin ID slot allocator: front end, queue, back end.
// Depends on rria_pkg, rria_front, rria_queue, rria_back (and rria_ram below it).
//
//   channel  | ports              | handshake
//   ---------+--------------------+--------------------------------------
//   item in  | start, busy, req   | taken at a rising edge with start & !busy
//   result   | done, rsp          | done high for one cycle, always taken
//
// Scan: allocate reads the ROWS bitmap words in the back end, one word read per
// cycle through the bitmap RAM read port (ROWS = ceil(SLOT_COUNT/32)), start word
// visited twice; release reads up to two words, lookup and flush one each.
// The front register and the queue lie between the item port and the back end.
// Reset: synchronous rst clears the row marks of the bitmap at once, so all
// slots read free; no clearing pass is needed.
// Stalls: busy rises only when the front register and the two-entry queue
// are both full; results are never held back.
module round_robin_id_slot_allocator
  import rria_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   req,
  output logic    done,
  output result_t rsp
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t fr_cmd;
  cmd_t head;

  rria_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .q_full (q_full),
    .push   (push),
    .cmd    (fr_cmd)
  );

  rria_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (fr_cmd),
    .full  (q_full),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty)
  );

  rria_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (q_empty),
    .head  (head),
    .pop   (pop),
    .done  (done),
    .rsp   (rsp)
  );

endmodule

[bench/round_robin_id_slot_allocator_tb.sv]
// Self-checking bench for round_robin_id_slot_allocator: directed and random commands
// against an in-bench allocator model. Depends on rria_pkg and the block's RTL only.
module round_robin_id_slot_allocator_tb;
  import rria_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 1024;
  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 60;
  localparam int MAX_REPORTS = 10;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   req   = '0;
  logic    busy;
  logic    done;
  result_t rsp;

  // Allocator model state
  bit slot_taken [SLOTS];
  int last_id = 0;
  int pend_id = 0;

  // Command stream and replies still owed by the block
  item_t   queued_cmds [$];
  result_t due_replies [$];

  int total_cmds  = 0;
  int sent_count  = 0;
  int reply_count = 0;
  int hold_off    = 0;
  int calm_left   = 0;
  int err_count   = 0;
  int cycle_count = 0;

  // Coverage tallies kept by the model
  int n_granted  = 0;
  int n_full     = 0;
  int n_deferred = 0;
  int n_live     = 0;
  int n_zero     = 0;

  round_robin_id_slot_allocator #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drop the pending release, if any
  function automatic void flush_pending();
    if (pend_id != 0) begin
      if (pend_id < SLOTS) slot_taken[pend_id] = 1'b0;
      pend_id = 0;
    end
  endfunction

  // Compute the reply to one command and advance the model
  function automatic result_t predict_reply(item_t cmd);
    result_t r;
    int      id;
    int      first;
    int      pick;
    int      i;
    bit      got;
    r     = '0;
    id    = int'(cmd.slot_id);
    got   = 1'b0;
    pick  = 0;
    case (cmd.mode)
      MODE_ALLOC: begin
        // Step the round-robin pointer, then search upward and wrap from zero
        last_id = last_id + 1;
        if (last_id >= SLOTS) last_id = 1;
        first = last_id;
        for (i = first; i < SLOTS && !got; i++) begin
          if (!slot_taken[i]) begin
            got  = 1'b1;
            pick = i;
          end
        end
        for (i = 0; i < first && !got; i++) begin
          if (!slot_taken[i]) begin
            got  = 1'b1;
            pick = i;
          end
        end
        if (!got) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          slot_taken[pick] = 1'b1;
          last_id          = pick;
          r.result_id      = pick[ID_W-1:0];
          n_granted++;
          if (pick == 0) n_zero++;
        end
      end
      MODE_RELEASE: begin
        r.result_id = cmd.slot_id;
        if (id >= SLOTS) begin
          r.status = STATUS_RANGE;
        end else begin
          flush_pending();
          if (cmd.is_current) begin
            pend_id = id;
            n_deferred++;
          end else begin
            slot_taken[id] = 1'b0;
          end
        end
      end
      MODE_LOOKUP: begin
        r.result_id = cmd.slot_id;
        if (id >= SLOTS) begin
          r.status = STATUS_RANGE;
        end else begin
          r.occupied = slot_taken[id];
          r.found    = slot_taken[id] && !(pend_id != 0 && pend_id == id);
          if (r.found) n_live++;
        end
      end
      default: begin
        flush_pending();
      end
    endcase
    return r;
  endfunction

  // Pick the idle time after an item: mostly none or short, a few long, calm stretches
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Queue one command
  task automatic push_cmd(logic [MODE_W-1:0] m, int id, bit cur);
    item_t c;
    c.mode       = m;
    c.slot_id    = id[ID_W-1:0];
    c.is_current = cur;
    queued_cmds.insert(queued_cmds.size(), c);
  endtask

  // Record one failure, report only the first few
  task automatic note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // Driver: present queued items, hold while busy, idle at random
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_replies.insert(due_replies.size(), predict_reply(req));
        sent_count++;
        hold_off = next_gap();
      end
      if (start && busy) begin
        // hold the item until it is taken
      end else if (hold_off > 0) begin
        hold_off--;
        start <= 1'b0;
      end else if (queued_cmds.size() > 0) begin
        req   <= queued_cmds.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: match every strobed reply against the oldest one owed
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (due_replies.size() == 0) begin
        note_error($sformatf("reply with nothing owed: id=%0d st=%0d f=%0b o=%0b",
                             rsp.result_id, rsp.status, rsp.found, rsp.occupied));
      end else begin
        want = due_replies.pop_front();
        if (rsp.result_id !== want.result_id || rsp.status !== want.status ||
            rsp.found !== want.found || rsp.occupied !== want.occupied) begin
          note_error($sformatf(
            "reply %0d: want id=%0d st=%0d f=%0b o=%0b, got id=%0d st=%0d f=%0b o=%0b",
            reply_count, want.result_id, want.status, want.found, want.occupied,
            rsp.result_id, rsp.status, rsp.found, rsp.occupied));
        end
        reply_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("round_robin_id_slot_allocator_tb: errors");
      $finish;
    end
  end

  initial begin
    int r;
    int hi;
    int allocs;
    int burst;
    int id;

    // Directed: grants, deferred release, repeat deferral, flush, free-slot release
    push_cmd(MODE_ALLOC,   0,    1'b0);
    push_cmd(MODE_ALLOC,   0,    1'b0);
    push_cmd(MODE_ALLOC,   0,    1'b0);
    push_cmd(MODE_LOOKUP,  2,    1'b0);
    push_cmd(MODE_RELEASE, 2,    1'b1);
    push_cmd(MODE_LOOKUP,  2,    1'b0);
    push_cmd(MODE_RELEASE, 2,    1'b1);
    push_cmd(MODE_LOOKUP,  2,    1'b0);
    push_cmd(MODE_FLUSH,   0,    1'b0);
    push_cmd(MODE_LOOKUP,  2,    1'b0);
    push_cmd(MODE_RELEASE, 5,    1'b0);
    push_cmd(MODE_RELEASE, 1,    1'b1);
    push_cmd(MODE_RELEASE, 3,    1'b0);
    push_cmd(MODE_LOOKUP,  1,    1'b0);
    push_cmd(MODE_LOOKUP,  1023, 1'b0);
    push_cmd(MODE_LOOKUP,  0,    1'b0);
    push_cmd(MODE_RELEASE, 0,    1'b1);
    push_cmd(MODE_FLUSH,   0,    1'b0);
    push_cmd(MODE_RELEASE, 1023, 1'b1);
    push_cmd(MODE_ALLOC,   1023, 1'b1);
    push_cmd(MODE_FLUSH,   1023, 1'b1);
    push_cmd(MODE_LOOKUP,  0,    1'b1);

    // Random, sparse table: IDs near the low end that have likely been handed out
    allocs = 3;
    repeat (300) begin
      r  = $urandom_range(0, 99);
      hi = (allocs + 3 > SLOTS - 1) ? SLOTS - 1 : allocs + 3;
      id = ($urandom_range(0, 19) == 0) ? $urandom_range(0, SLOTS - 1)
                                        : $urandom_range(0, hi);
      if (r < 40) begin
        push_cmd(MODE_ALLOC, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1)));
        allocs++;
      end else if (r < 70) begin
        push_cmd(MODE_RELEASE, id, $urandom_range(0, 9) < 3);
      end else if (r < 90) begin
        push_cmd(MODE_LOOKUP, id, 1'($urandom_range(0, 1)));
      end else begin
        push_cmd(MODE_FLUSH, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1)));
      end
    end

    // Fill burst: enough grants to exhaust the table from any state, wrap onto slot zero
    burst = 0;
    while (burst < SLOTS + 6) begin
      if ($urandom_range(0, 99) < 12) begin
        push_cmd(MODE_LOOKUP, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1)));
      end else begin
        push_cmd(MODE_ALLOC, $urandom_range(0, SLOTS - 1), 1'($urandom_range(0, 1)));
        burst++;
      end
    end

    // Random, near-full table: churn releases against grants, hit the ID extremes
    while (queued_cmds.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       id = 0;
        1:       id = SLOTS - 1;
        default: id = $urandom_range(0, SLOTS - 1);
      endcase
      if (r < 38) begin
        push_cmd(MODE_ALLOC, id, 1'($urandom_range(0, 1)));
      end else if (r < 72) begin
        push_cmd(MODE_RELEASE, id, $urandom_range(0, 99) < 35);
      end else if (r < 92) begin
        push_cmd(MODE_LOOKUP, id, 1'($urandom_range(0, 1)));
      end else begin
        push_cmd(MODE_FLUSH, id, 1'($urandom_range(0, 1)));
      end
    end
    total_cmds = queued_cmds.size();

    // Hold reset, then release it
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken and every reply to come back
    while (sent_count < total_cmds) @(negedge clk);
    while (due_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d commands: %0d IDs granted (%0d of them slot zero), %0d full answers",
             sent_count, n_granted, n_zero, n_full);
    $display("  %0d deferred releases, %0d live lookups, %0d failures",
             n_deferred, n_live, err_count);
    if (err_count == 0) begin
      $display("round_robin_id_slot_allocator_tb: clean");
    end else begin
      $display("round_robin_id_slot_allocator_tb: errors");
    end
    $finish;
  end

endmodule
